[design/lfpd_pkg.sv]
// ----------------------------------------------------------------------------
// lfpd_pkg
// shared types and constants of the length-framed packet deframer
// ----------------------------------------------------------------------------
package lfpd_pkg;

  localparam int unsigned ByteW = 8;

  // frame position codes
  localparam logic [ByteW-1:0] PosHunt   = 8'd0;  // waiting for header byte
  localparam logic [ByteW-1:0] PosLength = 8'd1;  // next byte is the length
  localparam logic [ByteW-1:0] PosBody   = 8'd2;  // first payload byte

  // header, length and two check bytes around the payload
  localparam int unsigned FrameOverhead = 4;

  // input beat kinds
  localparam logic KindByte  = 1'b0;
  localparam logic KindError = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] rx_byte;
  } lfpd_item_t;

  typedef struct packed {
    logic             store_valid;
    logic [ByteW-1:0] store_index;
    logic [ByteW-1:0] store_byte;
    logic             packet_done;
    logic             packet_ok;
    logic [ByteW-1:0] payload_length;
    logic             length_error;
  } lfpd_result_t;

endpackage

[design/lfpd_in_reg.sv]
// ----------------------------------------------------------------------------
// lfpd_in_reg
// input register stage, holds one accepted beat until the core takes it
// ----------------------------------------------------------------------------
module lfpd_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lfpd_pkg::lfpd_item_t in_item_i,
  output logic                item_valid_o,
  output lfpd_pkg::lfpd_item_t item_o,
  input  logic                take_i
);
  import lfpd_pkg::*;

  logic       valid_q, valid_d;
  lfpd_item_t item_q;

  // free when empty or when the held beat moves on this cycle
  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

[design/lfpd_step.sv]
// ----------------------------------------------------------------------------
// lfpd_step
// frame tracker and fletcher-16 sums, one beat per cycle while step_i is set
// ----------------------------------------------------------------------------
module lfpd_step #(
  parameter int unsigned MAX_PAYLOAD = 251
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_data_i,
  input  logic                  step_i,
  input  lfpd_pkg::lfpd_item_t  item_i,
  output lfpd_pkg::lfpd_result_t result_o
);
  import lfpd_pkg::*;

  localparam logic [ByteW-1:0] MaxLen = ByteW'(MAX_PAYLOAD);

  logic [ByteW-1:0] header_q;
  logic [ByteW-1:0] pos_q, pos_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] sum_lo_q, sum_lo_d;
  logic [ByteW-1:0] sum_hi_q, sum_hi_d;
  logic [ByteW-1:0] sum_lo_n, sum_hi_n;
  logic             last_byte;

  // a + b mod 255, a below 255, so one conditional subtract
  function automatic logic [ByteW-1:0] add_mod255(input logic [ByteW-1:0] a,
                                                  input logic [ByteW-1:0] b);
    logic [ByteW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 9'd255) begin
      s = s - 9'd255;
    end
    return s[ByteW-1:0];
  endfunction

  assign sum_lo_n  = add_mod255(sum_lo_q, item_i.rx_byte);
  assign sum_hi_n  = add_mod255(sum_hi_q, sum_lo_n);
  assign last_byte = ({1'b0, pos_q} + 9'd1) >=
                     ({1'b0, len_q} + 9'(FrameOverhead));

  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    sum_lo_d = sum_lo_n;
    sum_hi_d = sum_hi_n;
    result_o = '0;
    if (item_i.kind == KindError) begin
      pos_d    = PosHunt;
      len_d    = '0;
      sum_lo_d = '0;
      sum_hi_d = '0;
    end else if (pos_q == PosHunt) begin
      if (item_i.rx_byte != header_q) begin
        sum_lo_d = '0;
        sum_hi_d = '0;
      end else begin
        pos_d = PosLength;
      end
    end else if (pos_q == PosLength) begin
      if (item_i.rx_byte > MaxLen) begin
        pos_d                 = PosHunt;
        len_d                 = '0;
        sum_lo_d              = '0;
        sum_hi_d              = '0;
        result_o.length_error = 1'b1;
      end else begin
        len_d = item_i.rx_byte;
        pos_d = PosBody;
      end
    end else begin
      result_o.store_valid = 1'b1;
      result_o.store_index = pos_q - PosBody;
      result_o.store_byte  = item_i.rx_byte;
      if (last_byte) begin
        result_o.packet_done    = 1'b1;
        result_o.packet_ok      = (sum_lo_n == '0) && (sum_hi_n == '0);
        result_o.payload_length = len_q;
        pos_d                   = PosHunt;
        sum_lo_d                = '0;
        sum_hi_d                = '0;
      end else begin
        pos_d = pos_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= '0;
      pos_q    <= PosHunt;
      len_q    <= '0;
      sum_lo_q <= '0;
      sum_hi_q <= '0;
    end else begin
      if (cfg_we_i) begin
        header_q <= cfg_data_i;
      end
      if (step_i) begin
        pos_q    <= pos_d;
        len_q    <= len_d;
        sum_lo_q <= sum_lo_d;
        sum_hi_q <= sum_hi_d;
      end
    end
  end

endmodule

[design/lfpd_out_reg.sv]
// ----------------------------------------------------------------------------
// lfpd_out_reg
// result register, holds a result beat until the consumer takes it
// ----------------------------------------------------------------------------
module lfpd_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  lfpd_pkg::lfpd_result_t result_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output lfpd_pkg::lfpd_result_t result_o
);
  import lfpd_pkg::*;

  logic         valid_q, valid_d;
  lfpd_result_t result_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

[design/length_framed_packet_deframer_unit.sv]
// ----------------------------------------------------------------------------
// length_framed_packet_deframer_unit
// length-prefixed frame parser with fletcher-16 check for a uart byte stream
// ----------------------------------------------------------------------------
// Takes one beat per clock while s_axis_tready is high: either a received
// byte or a receive error event. The block hunts for the header byte in
// header_value, then reads a length byte, that many payload bytes and two
// check bytes. Every byte after the length comes out flagged for storage
// with its buffer index. On the last check byte the result beat carries done
// (tlast), the payload length and ok when both fletcher-16 sums (mod 255,
// over header through check bytes) are zero. A length above MAX_PAYLOAD
// drops the frame and raises length_error; an error event silently aborts
// any frame. Every input beat yields exactly one result beat, held first in
// the input register and then in the result register, where it waits while
// the consumer stalls. Throughput is one beat per clock while m_axis_tready
// stays high; the position counter and the two chained mod-255 adds update
// on every accepted beat. header_value is written through the cfg channel,
// which is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module length_framed_packet_deframer_unit #(
  parameter int unsigned MAX_PAYLOAD = 251
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel: header_value
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] kind (1 = receive error)
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] store_index, [15:8] store_byte,
                                      // [23:16] payload_length
  output logic [2:0]  m_axis_tuser,   // [0] store_valid, [1] packet_ok,
                                      // [2] length_error
  output logic        m_axis_tlast    // packet_done
);
  import lfpd_pkg::*;

  lfpd_item_t   in_item;
  lfpd_item_t   item;
  logic         item_valid;
  lfpd_result_t step_result;
  lfpd_result_t out_result;
  logic         out_free;
  logic         advance;

  assign in_item.kind    = s_axis_tuser;
  assign in_item.rx_byte = s_axis_tdata;

  // held beat moves into the result register when that slot frees up
  assign advance = item_valid && out_free;

  assign cfg_ready_o = 1'b1;

  lfpd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .take_i       (advance)
  );

  // frame state only moves when a beat actually advances
  lfpd_step #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .step_i     (advance),
    .item_i     (item),
    .result_o   (step_result)
  );

  lfpd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (step_result),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (out_result)
  );

  // pack result fields onto the stream
  assign m_axis_tdata = {out_result.payload_length, out_result.store_byte,
                         out_result.store_index};
  assign m_axis_tuser = {out_result.length_error, out_result.packet_ok,
                         out_result.store_valid};
  assign m_axis_tlast = out_result.packet_done;

endmodule

[design/lfpd_checker.sv]
// ----------------------------------------------------------------------------
// lfpd_port_checker
// port-level checks on the result stream of the deframer
// ----------------------------------------------------------------------------
module lfpd_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // no store index or byte without a store
  a_store_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[15:0] == 16'd0)
    else $error("store fields set without store_valid");

  // ok and length only on a completed frame
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |->
      m_axis_tdata[23:16] == 8'd0 && !m_axis_tuser[1])
    else $error("completion fields set without packet_done");

  // a frame completes on a stored check byte
  a_done_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("packet_done without store_valid");

  // length error stands alone
  a_len_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |->
      !m_axis_tuser[0] && !m_axis_tlast && !m_axis_tuser[1])
    else $error("length_error together with other flags");

endmodule

bind length_framed_packet_deframer_unit lfpd_port_checker u_lfpd_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
